// ----- hdl/text_console_cursor_scroll_unit_defines.svh -----
// assertion macros for the text console cursor and scroll unit
// used by the top level only; expects signals clk and rst in scope
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define TCCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCS_ASSERT(lbl, prop, msg)
`define TCCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/tccs_pkg.sv -----
// shared types and constants of the text console cursor and scroll unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tccs_pkg;

  // screen geometry and field widths
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int MEM_DEPTH = ROWS * (2 ** COL_W);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_BS    = 3'd1;
  localparam logic [2:0] CMD_UP    = 3'd2;
  localparam logic [2:0] CMD_DOWN  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_SHOW  = 3'd5;
  localparam logic [2:0] CMD_HIDE  = 3'd6;
  localparam logic [2:0] CMD_READ  = 3'd7;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CURSOR_MARK = 8'd128;
  localparam logic [COL_W:0] TAB_MASK = (COL_W + 1)'(3);

  // one result item
  typedef struct packed {
    logic             write_valid;
    logic [ROW_W-1:0] write_row;
    logic [COL_W-1:0] write_col;
    logic [7:0]       write_data;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] top_line;
    logic             repaint;
    logic [7:0]       read_data;
  } result_t;

  // one classified item for the back end
  typedef struct packed {
    logic             mem_wr;
    logic             mem_rd;
    logic             rd_to_write;
    logic             mark;
    logic             clr_line;
    logic             clr_all;
    logic [ROW_W-1:0] line;
    logic [COL_W-1:0] col;
    logic [7:0]       wchar;
    logic [ROW_W-1:0] clr_idx;
    result_t          res;
  } job_t;

  // back end status seen by the top level
  typedef struct packed {
    logic init;
  } back_status_t;

endpackage

// ----- hdl/tccs_front.sv -----
// front end: holds cursor and top line, classifies each command into a job
// depends on tccs_pkg
`timescale 1ns / 1ps
module tccs_front import tccs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [2:0]       command,
  input  logic [7:0]       char_code,
  input  logic [ROW_W-1:0] read_row,
  input  logic [COL_W-1:0] read_col,
  output job_t             job
);

  logic [ROW_W-1:0] top_line, top_line_next;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic [COL_W-1:0] cursor_col, cursor_col_next;

  logic [ROW_W:0]   cur_sum, rd_sum;
  logic [ROW_W-1:0] cur_line, rd_line;
  logic [ROW_W-1:0] top_inc, top_dec;
  logic [COL_W:0]   tab_col, col_inc;
  logic             row_last, wrap, rep, rd_in_range;

  // ring line of the cursor row and of the read row
  always_comb begin
    cur_sum = {1'b0, top_line} + {1'b0, cursor_row};
    if (cur_sum >= (ROW_W + 1)'(ROWS)) cur_sum = cur_sum - (ROW_W + 1)'(ROWS);
    cur_line = cur_sum[ROW_W-1:0];
    rd_sum = {1'b0, top_line} + {1'b0, read_row};
    if (rd_sum >= (ROW_W + 1)'(ROWS)) rd_sum = rd_sum - (ROW_W + 1)'(ROWS);
    rd_line = rd_sum[ROW_W-1:0];
  end

  assign top_inc = (top_line == ROW_W'(ROWS - 1)) ? '0 : top_line + 1'b1;
  assign top_dec = (top_line == '0) ? ROW_W'(ROWS - 1) : top_line - 1'b1;
  assign tab_col = ({1'b0, cursor_col} | TAB_MASK) + 1'b1;
  assign col_inc = {1'b0, cursor_col} + 1'b1;
  assign row_last = (cursor_row == ROW_W'(ROWS - 1));
  assign rd_in_range = ({1'b0, read_row} < (ROW_W + 1)'(ROWS)) &&
                       ({1'b0, read_col} < (COL_W + 1)'(COLS));

  // classify the command and work out the next cursor and top line
  always_comb begin
    job = '0;
    top_line_next = top_line;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    wrap = 1'b0;
    rep = 1'b0;
    case (command)
      CMD_PUT: begin
        if (char_code == CH_NL) begin
          wrap = 1'b1;
        end else if (char_code == CH_TAB) begin
          if (tab_col >= (COL_W + 1)'(COLS)) wrap = 1'b1;
          else cursor_col_next = tab_col[COL_W-1:0];
        end else if (char_code != CH_CR) begin
          job.mem_wr = 1'b1;
          job.line = cur_line;
          job.col = cursor_col;
          job.wchar = char_code;
          job.res.write_valid = 1'b1;
          job.res.write_row = cursor_row;
          job.res.write_col = cursor_col;
          job.res.write_data = char_code;
          if (col_inc >= (COL_W + 1)'(COLS)) wrap = 1'b1;
          else cursor_col_next = col_inc[COL_W-1:0];
        end
      end
      CMD_BS: begin
        if (cursor_col != '0) begin
          cursor_col_next = cursor_col - 1'b1;
          job.mem_wr = 1'b1;
          job.line = cur_line;
          job.col = cursor_col - 1'b1;
          job.wchar = CH_SPACE;
          job.res.write_valid = 1'b1;
          job.res.write_row = cursor_row;
          job.res.write_col = cursor_col - 1'b1;
          job.res.write_data = CH_SPACE;
        end
      end
      CMD_UP: begin
        job.clr_line = 1'b1;
        job.clr_idx = top_line;
        top_line_next = top_inc;
        if (cursor_row != '0) cursor_row_next = cursor_row - 1'b1;
        rep = 1'b1;
      end
      CMD_DOWN: begin
        job.clr_line = 1'b1;
        job.clr_idx = top_dec;
        top_line_next = top_dec;
        if (!row_last) cursor_row_next = cursor_row + 1'b1;
        rep = 1'b1;
      end
      CMD_CLEAR: begin
        job.clr_all = 1'b1;
        top_line_next = '0;
        cursor_row_next = '0;
        cursor_col_next = '0;
        rep = 1'b1;
      end
      CMD_SHOW, CMD_HIDE: begin
        job.mem_rd = 1'b1;
        job.rd_to_write = 1'b1;
        job.mark = (command == CMD_SHOW);
        job.line = cur_line;
        job.col = cursor_col;
        job.res.write_valid = 1'b1;
        job.res.write_row = cursor_row;
        job.res.write_col = cursor_col;
      end
      default: begin
        // read cell; outside the screen reads as zero
        if (rd_in_range) begin
          job.mem_rd = 1'b1;
          job.line = rd_line;
          job.col = read_col;
        end
      end
    endcase

    // next row, with a scroll up past the bottom
    if (wrap) begin
      cursor_col_next = '0;
      if (row_last) begin
        job.clr_line = 1'b1;
        job.clr_idx = top_line;
        top_line_next = top_inc;
        rep = 1'b1;
      end else begin
        cursor_row_next = cursor_row + 1'b1;
      end
    end

    job.res.cursor_row = cursor_row_next;
    job.res.cursor_col = cursor_col_next;
    job.res.top_line = top_line_next;
    job.res.repaint = rep;
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      top_line <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
    end else if (accept) begin
      top_line <= top_line_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
    end
  end

endmodule

// ----- hdl/tccs_queue.sv -----
// small job queue between the front and back ends
// depends on tccs_pkg
`timescale 1ns / 1ps
module tccs_queue import tccs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- hdl/tccs_back.sv -----
// back end: owns the line store, carries out jobs and drives the results
// depends on tccs_pkg
`timescale 1ns / 1ps
module tccs_back import tccs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  job_t         head,
  input  logic         empty,
  output logic         pop,
  output back_status_t status,
  output logic         done,
  output result_t      result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]       state;
  logic             init;
  logic             sweep_all;
  logic [ROW_W-1:0] sw_line;
  logic [COL_W-1:0] sw_col;
  job_t             cur;
  result_t          read_res;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;
  logic              sweep_end;

  assign pop = (state == S_IDLE) && !empty;
  assign status.init = init;
  assign sweep_end = (sw_col == COL_W'(COLS - 1)) &&
                     (!sweep_all || sw_line == ROW_W'(ROWS - 1));

  // store port: one write, one registered read
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {cur.line, cur.col};
    mem_wdata = cur.wchar;
    if (state == S_EXEC && cur.mem_wr) begin
      mem_we = 1'b1;
    end else if (state == S_SWEEP) begin
      mem_we = 1'b1;
      mem_waddr = {sw_line, sw_col};
      mem_wdata = CH_SPACE;
    end
  end
  assign mem_raddr = {cur.line, cur.col};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // result of a store read, with the cursor mark where shown
  always_comb begin
    read_res = cur.res;
    if (cur.rd_to_write) begin
      read_res.write_data = cur.mark ? mem_q + CURSOR_MARK : mem_q;
    end else begin
      read_res.read_data = mem_q;
    end
  end

  // job sequencer; reset starts a clearing pass over all screen cells of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      init <= 1'b1;
      sweep_all <= 1'b1;
      sw_line <= '0;
      sw_col <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cur <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur.clr_line || cur.clr_all) begin
            sweep_all <= cur.clr_all;
            sw_line <= cur.clr_all ? '0 : cur.clr_idx;
            sw_col <= '0;
            state <= S_SWEEP;
          end else if (cur.mem_rd) begin
            state <= S_READ;
          end else begin
            result <= cur.res;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (sweep_end) begin
            if (!init) begin
              result <= cur.res;
              done <= 1'b1;
            end
            init <= 1'b0;
            state <= S_IDLE;
          end else if (sw_col == COL_W'(COLS - 1)) begin
            sw_col <= '0;
            sw_line <= sw_line + 1'b1;
          end else begin
            sw_col <= sw_col + 1'b1;
          end
        end
        S_READ: begin
          result <= read_res;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/text_console_cursor_scroll_unit.sv -----
// top level of the text console cursor and scroll unit
// depends on tccs_pkg, tccs_front, tccs_queue, tccs_back and the defines header
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; its single result
// appears later for one cycle with done high and cannot be held off. After
// reset the line store is cleared to spaces in a pass over its ROWS*COLS
// screen cells, during which busy stays high. The front end updates cursor
// and top line as it takes a command and queues the job (two deep), so
// commands can be taken while earlier ones still run. In the back end, which
// owns the line store, put char, backspace, newline, tab and a read cell
// outside the screen need only the execute state; show, hide and an on-screen
// read cell add a store read, a scroll (explicit or at the bottom row) adds a
// sweep that clears one line, and clear adds a sweep over the whole screen.
`include "text_console_cursor_scroll_unit_defines.svh"
module text_console_cursor_scroll_unit import tccs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       command,
  input  logic [7:0]       char_code,
  input  logic [ROW_W-1:0] read_row,
  input  logic [COL_W-1:0] read_col,
  output logic             done,
  output logic             write_valid,
  output logic [ROW_W-1:0] write_row,
  output logic [COL_W-1:0] write_col,
  output logic [7:0]       write_data,
  output logic [ROW_W-1:0] cursor_row_out,
  output logic [COL_W-1:0] cursor_col_out,
  output logic [ROW_W-1:0] top_line_out,
  output logic             repaint,
  output logic [7:0]       read_data
);

  job_t         new_job, head;
  logic         accept, pop, q_empty, q_full;
  back_status_t back_st;
  result_t      result;
  logic         on_screen, quiet_write;

  // an item is taken once the store is cleared and the queue has room
  assign busy = back_st.init || q_full;
  assign accept = start && !busy;

  tccs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .job       (new_job)
  );

  tccs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (new_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tccs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .status (back_st),
    .done   (done),
    .result (result)
  );

  // result ports
  assign write_valid = result.write_valid;
  assign write_row = result.write_row;
  assign write_col = result.write_col;
  assign write_data = result.write_data;
  assign cursor_row_out = result.cursor_row;
  assign cursor_col_out = result.cursor_col;
  assign top_line_out = result.top_line;
  assign repaint = result.repaint;
  assign read_data = result.read_data;

  // checks
  assign on_screen = (cursor_row_out < ROW_W'(ROWS)) && (cursor_col_out < COL_W'(COLS)) &&
                     (top_line_out < ROW_W'(ROWS));
  assign quiet_write = (write_row == '0) && (write_col == '0) && (write_data == '0);

  `TCCS_ASSERT(a_no_result_in_init, back_st.init |-> !done, "result during clearing pass")
  `TCCS_ASSERT(a_state_on_screen, done |-> on_screen, "cursor or top line off screen")
  `TCCS_ASSERT(a_quiet_no_write, (done && !write_valid) |-> quiet_write, "stray write fields")
  `TCCS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done && busy, "result or ready right after reset")

endmodule
